[src/mtru_pkg.sv]
// Shared types, constants and table functions for the mip tile refcount update unit.
// No dependencies.
package mtru_pkg;

   localparam int MAX_TILES_WIDE_DEF = 128;
   localparam int MAX_TILES_HIGH_DEF = 128;
   localparam int MAX_MIPS_DEF       = 8;
   localparam int COUNT_BITS_DEF     = 16;

   typedef enum logic [1:0] {
      CSR_MAX_MIP    = 2'd0,
      CSR_MAP_WIDTH  = 2'd1,
      CSR_MAP_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_CHANGE = 2'd0,
      ACT_LOAD   = 2'd1,
      ACT_EVICT  = 2'd2,
      ACT_ERROR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      JOB_FEED  = 2'd0,
      JOB_BAD   = 2'd1,
      JOB_CLEAR = 2'd2
   } job_kind_type;

   typedef enum logic [2:0] {
      B_SWEEP = 3'd0,
      B_IDLE  = 3'd1,
      B_BAD   = 3'd2,
      B_WREAD = 3'd3,
      B_WCHK  = 3'd4,
      B_CADDR = 3'd5,
      B_CREAD = 3'd6,
      B_CUPD  = 3'd7
   } back_state_type;

   typedef struct packed {
      logic       cmd;
      logic [6:0] tile_x;
      logic [6:0] tile_y;
      logic [7:0] feedback_mip;
   } req_word_type;

   typedef struct packed {
      action_type action;
      logic [6:0] out_x;
      logic [6:0] out_y;
      logic [2:0] out_mip;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      job_kind_type kind;
      logic [6:0]   x;
      logic [6:0]   y;
      logic [3:0]   want;
   } job_type;

   typedef struct packed {
      logic sweeping;
   } back_status_type;

   function automatic int layer_wide(int s, int w);
      return (w + (1 << s) - 1) >> s;
   endfunction

   function automatic int layer_base(int s, int w, int h);
      int b;
      b = 0;
      for (int i = 0; i < s; i++) begin
         b += ((w + (1 << i) - 1) >> i) * ((h + (1 << i) - 1) >> i);
      end
      return b;
   endfunction

   function automatic int addr_bits(int n);
      return (n < 2) ? 1 : $clog2(n);
   endfunction

endpackage

[src/mtru_front.sv]
// Front end: configuration registers, input word classification and clamping.
// Depends on mtru_pkg.
module mtru_front #(
   parameter int MAX_TILES_WIDE = mtru_pkg::MAX_TILES_WIDE_DEF,
   parameter int MAX_TILES_HIGH = mtru_pkg::MAX_TILES_HIGH_DEF,
   parameter int MAX_MIPS       = mtru_pkg::MAX_MIPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mtru_pkg::req_word_type  req_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_data,
   input  mtru_pkg::back_status_type status,
   output logic                    q_push,
   input  logic                    q_ready,
   output mtru_pkg::job_type       q_job
);

   logic [3:0] max_mip_ff, max_mip_in;
   logic [7:0] map_width_ff, map_width_in;
   logic [7:0] map_height_ff, map_height_in;
   logic [3:0] mx;
   logic       bad;

   assign csr_ready = 1'b1;

   always_comb begin
      max_mip_in    = max_mip_ff;
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_valid) begin
         case (mtru_pkg::csr_index_type'(csr_index))
            mtru_pkg::CSR_MAX_MIP:    max_mip_in    = csr_data[3:0];
            mtru_pkg::CSR_MAP_WIDTH:  map_width_in  = csr_data;
            mtru_pkg::CSR_MAP_HEIGHT: map_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_mip_ff    <= 4'(MAX_MIPS);
         map_width_ff  <= 8'd128;
         map_height_ff <= 8'd128;
      end else begin
         max_mip_ff    <= max_mip_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   assign mx = (32'(max_mip_ff) > 32'(MAX_MIPS)) ? 4'(MAX_MIPS) : max_mip_ff;

   assign bad = ({1'b0, req_word.tile_x} >= map_width_ff)
             || ({1'b0, req_word.tile_y} >= map_height_ff)
             || (32'(req_word.tile_x) >= 32'(MAX_TILES_WIDE))
             || (32'(req_word.tile_y) >= 32'(MAX_TILES_HIGH));

   assign req_ready = q_ready && !status.sweeping;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_job.x    = req_word.tile_x;
      q_job.y    = req_word.tile_y;
      q_job.want = (req_word.feedback_mip < {4'd0, mx}) ? req_word.feedback_mip[3:0] : mx;
      if (req_word.cmd) begin
         q_job.kind = mtru_pkg::JOB_CLEAR;
         q_job.want = mx;
      end else if (bad) begin
         q_job.kind = mtru_pkg::JOB_BAD;
      end else begin
         q_job.kind = mtru_pkg::JOB_FEED;
      end
   end

endmodule

[src/mtru_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on mtru_pkg.
module mtru_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              push_ready,
   input  mtru_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop,
   output mtru_pkg::job_type pop_job
);

   mtru_pkg::job_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_job    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

[src/mtru_back.sv]
// Back end: wanted-mip and reference count memories, per-layer update sequencer,
// clearing sweep and result register. Depends on mtru_pkg.
module mtru_back #(
   parameter int MAX_TILES_WIDE = mtru_pkg::MAX_TILES_WIDE_DEF,
   parameter int MAX_TILES_HIGH = mtru_pkg::MAX_TILES_HIGH_DEF,
   parameter int MAX_MIPS       = mtru_pkg::MAX_MIPS_DEF,
   parameter int COUNT_BITS     = mtru_pkg::COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  mtru_pkg::job_type         q_job,
   output mtru_pkg::back_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mtru_pkg::rsp_word_type    rsp_word
);

   localparam int MAP_DEPTH   = MAX_TILES_WIDE * MAX_TILES_HIGH;
   localparam int COUNT_WORDS = mtru_pkg::layer_base(MAX_MIPS, MAX_TILES_WIDE, MAX_TILES_HIGH);
   localparam int SWEEP_LEN   = (MAP_DEPTH > COUNT_WORDS) ? MAP_DEPTH : COUNT_WORDS;
   localparam int MIW         = mtru_pkg::addr_bits(MAP_DEPTH);
   localparam int CIW         = mtru_pkg::addr_bits(COUNT_WORDS);
   localparam int SWW         = $clog2(SWEEP_LEN + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [31:0] base_tab [16];
   logic [31:0] wide_tab [16];

   for (genvar g = 0; g < 16; g++) begin : g_tab
      assign base_tab[g] = 32'(mtru_pkg::layer_base(g, MAX_TILES_WIDE, MAX_TILES_HIGH));
      assign wide_tab[g] = 32'(mtru_pkg::layer_wide(g, MAX_TILES_WIDE));
   end

   logic [3:0]            wmem [MAP_DEPTH];
   logic [COUNT_BITS-1:0] cmem [COUNT_WORDS];

   mtru_pkg::back_state_type state_ff, state_in;
   mtru_pkg::job_type        job_ff, job_in;
   logic [MIW-1:0]        idx_ff, idx_in;
   logic [CIW-1:0]        ci_ff, ci_in;
   logic [3:0]            lay_ff, lay_in;
   logic                  up_ff, up_in;
   logic [SWW-1:0]        sw_ff, sw_in;
   logic [3:0]            clr_ff, clr_in;
   logic [3:0]            wrd_ff;
   logic [COUNT_BITS-1:0] crd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   mtru_pkg::rsp_word_type rsp_ff, rsp_in;

   logic                  out_free, out_push, wrd_en, crd_en, cmem_we, wmem_we;
   logic                  sweep_end, step_last, cnt_err;
   logic [3:0]            cur;
   logic [6:0]            lx, ly;
   logic [COUNT_BITS-1:0] cnt_new;
   mtru_pkg::action_type  act;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sweep_end = sw_ff == SWW'(SWEEP_LEN - 1);
   assign cur       = (32'(wrd_ff) > 32'(MAX_MIPS)) ? 4'(MAX_MIPS) : wrd_ff;
   assign lx        = job_ff.x >> lay_ff;
   assign ly        = job_ff.y >> lay_ff;
   assign step_last = up_ff ? (lay_ff == job_ff.want) : ((lay_ff + 4'd1) == job_ff.want);

   always_comb begin
      cnt_err = 1'b0;
      cnt_new = crd_ff;
      act     = mtru_pkg::ACT_CHANGE;
      if (up_ff) begin
         if (crd_ff == COUNT_MAX) begin
            cnt_err = 1'b1;
            act     = mtru_pkg::ACT_ERROR;
         end else begin
            cnt_new = crd_ff + COUNT_BITS'(1);
            if (crd_ff == '0) act = mtru_pkg::ACT_LOAD;
         end
      end else begin
         if (crd_ff == '0) begin
            cnt_err = 1'b1;
            act     = mtru_pkg::ACT_ERROR;
         end else begin
            cnt_new = crd_ff - COUNT_BITS'(1);
            if (crd_ff == COUNT_BITS'(1)) act = mtru_pkg::ACT_EVICT;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtru_pkg::B_SWEEP: if (sweep_end) state_in = mtru_pkg::B_IDLE;
         mtru_pkg::B_IDLE: begin
            if (q_valid) begin
               case (q_job.kind)
                  mtru_pkg::JOB_CLEAR: state_in = mtru_pkg::B_SWEEP;
                  mtru_pkg::JOB_BAD:   state_in = mtru_pkg::B_BAD;
                  default:             state_in = mtru_pkg::B_WREAD;
               endcase
            end
         end
         mtru_pkg::B_BAD:   if (out_free) state_in = mtru_pkg::B_IDLE;
         mtru_pkg::B_WREAD: state_in = mtru_pkg::B_WCHK;
         mtru_pkg::B_WCHK:
            state_in = (cur == job_ff.want) ? mtru_pkg::B_IDLE : mtru_pkg::B_CADDR;
         mtru_pkg::B_CADDR: state_in = mtru_pkg::B_CREAD;
         mtru_pkg::B_CREAD: state_in = mtru_pkg::B_CUPD;
         mtru_pkg::B_CUPD: begin
            if (out_free) state_in = step_last ? mtru_pkg::B_IDLE : mtru_pkg::B_CADDR;
         end
         default: state_in = mtru_pkg::B_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      q_pop    = 1'b0;
      out_push = 1'b0;
      wrd_en   = 1'b0;
      crd_en   = 1'b0;
      cmem_we  = 1'b0;
      wmem_we  = 1'b0;
      job_in   = job_ff;
      idx_in   = idx_ff;
      ci_in    = ci_ff;
      lay_in   = lay_ff;
      up_in    = up_ff;
      sw_in    = sw_ff;
      clr_in   = clr_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         mtru_pkg::B_SWEEP: begin
            sw_in = sw_ff + SWW'(1);
         end
         mtru_pkg::B_IDLE: begin
            q_pop  = q_valid;
            job_in = q_job;
            idx_in = MIW'(32'(q_job.y) * 32'(MAX_TILES_WIDE) + 32'(q_job.x));
            sw_in  = '0;
            clr_in = q_job.want;
         end
         mtru_pkg::B_BAD: begin
            out_push = out_free;
            rsp_in   = '{action: mtru_pkg::ACT_ERROR, out_x: job_ff.x, out_y: job_ff.y,
                         out_mip: 3'd0, last: 1'b1};
         end
         mtru_pkg::B_WREAD: begin
            wrd_en = 1'b1;
         end
         mtru_pkg::B_WCHK: begin
            up_in  = job_ff.want < cur;
            lay_in = (job_ff.want < cur) ? cur - 4'd1 : cur;
         end
         mtru_pkg::B_CADDR: begin
            ci_in = CIW'(base_tab[lay_ff] + 32'(ly) * wide_tab[lay_ff] + 32'(lx));
         end
         mtru_pkg::B_CREAD: begin
            crd_en = 1'b1;
         end
         mtru_pkg::B_CUPD: begin
            out_push = out_free;
            cmem_we  = out_free && !cnt_err;
            wmem_we  = out_free && step_last;
            lay_in   = out_free ? (up_ff ? lay_ff - 4'd1 : lay_ff + 4'd1) : lay_ff;
            rsp_in   = '{action: act, out_x: lx, out_y: ly, out_mip: lay_ff[2:0],
                         last: step_last};
         end
         default: ;
      endcase
      if (!out_push) rsp_in = rsp_ff;
      rsp_valid_in = out_push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtru_pkg::B_SWEEP;
         sw_ff        <= '0;
         clr_ff       <= 4'(MAX_MIPS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      ci_ff  <= ci_in;
      lay_ff <= lay_in;
      up_ff  <= up_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == mtru_pkg::B_SWEEP) begin
         if (32'(sw_ff) < 32'(MAP_DEPTH)) wmem[sw_ff[MIW-1:0]] <= clr_ff;
      end else if (wmem_we) begin
         wmem[idx_ff] <= job_ff.want;
      end
      if (wrd_en) wrd_ff <= wmem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == mtru_pkg::B_SWEEP) begin
         if (32'(sw_ff) < 32'(COUNT_WORDS)) cmem[sw_ff[CIW-1:0]] <= '0;
      end else if (cmem_we) begin
         cmem[ci_ff] <= cnt_new;
      end
      if (crd_en) crd_ff <= cmem[ci_ff];
   end

   assign status.sweeping = state_ff == mtru_pkg::B_SWEEP;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_ff;

`ifndef SYNTHESIS
   a_sweep_no_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == mtru_pkg::B_SWEEP |-> !out_push)
      else $error("result produced during clearing sweep");
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_push && rsp_in.last |=> state_ff == mtru_pkg::B_IDLE)
      else $error("sequencer continued after last result");
   a_addr_then_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == mtru_pkg::B_CADDR |=> state_ff == mtru_pkg::B_CREAD)
      else $error("count read skipped after address");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == mtru_pkg::B_IDLE && !rsp_valid_in || state_ff == mtru_pkg::B_IDLE)
      else $error("queue popped outside idle");
`endif

endmodule

[src/mip_tile_refcount_update_unit.sv]
// Top level of the mip tile refcount update unit: front, queue and back end.
// Depends on mtru_pkg, mtru_front, mtru_queue, mtru_back.
//
//  channel | ports                          | direction
//  req     | req_valid req_ready req_word   | in: feedback entry or clear
//  rsp     | rsp_valid rsp_ready rsp_word   | out: one word per touched layer
//  csr     | csr_valid csr_ready csr_index csr_data | in: register write
//
// A feedback word reads the wanted-mip memory, then for each touched layer does a
// registered read-modify-write on the count memory; a bad tile gives an error word.
// After reset and after a clear the back end sweeps both memories, one entry per
// cycle, over max(tiles wide * tiles high, total count entries) entries (21845 at
// defaults); req_ready is low during it. The result register stalls the back end
// only; the two-entry queue keeps accepting words while it has room.
module mip_tile_refcount_update_unit #(
   parameter int MAX_TILES_WIDE = mtru_pkg::MAX_TILES_WIDE_DEF,
   parameter int MAX_TILES_HIGH = mtru_pkg::MAX_TILES_HIGH_DEF,
   parameter int MAX_MIPS       = mtru_pkg::MAX_MIPS_DEF,
   parameter int COUNT_BITS     = mtru_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mtru_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mtru_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data
);

   mtru_pkg::back_status_type status;
   mtru_pkg::job_type         push_job, pop_job;
   logic                      push, push_ready, pop_valid, pop;

   mtru_front #(
      .MAX_TILES_WIDE(MAX_TILES_WIDE),
      .MAX_TILES_HIGH(MAX_TILES_HIGH),
      .MAX_MIPS(MAX_MIPS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .status(status),
      .q_push(push), .q_ready(push_ready), .q_job(push_job)
   );

   mtru_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_ready(push_ready), .push_job(push_job),
      .pop_valid(pop_valid), .pop(pop), .pop_job(pop_job)
   );

   mtru_back #(
      .MAX_TILES_WIDE(MAX_TILES_WIDE),
      .MAX_TILES_HIGH(MAX_TILES_HIGH),
      .MAX_MIPS(MAX_MIPS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_valid(pop_valid), .q_pop(pop), .q_job(pop_job),
      .status(status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

endmodule
